@@ sv/sus_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sus_pkg: shared types and constants for the sorted unique set
// Operation codes, field widths and the queued operation beat.
// ----------------------------------------------------------------------------
package sus_pkg;

    localparam int MAX_RESULTS      = 16;
    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W          = 32;
    localparam int COUNT_W          = 5;
    localparam int POS_W            = 4;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    typedef struct packed {
        logic               func;
        logic [VALUE_W-1:0] value;
    } sus_op_t;

    // handshake between the front queue and the back end
    typedef struct packed {
        logic valid;
    } sus_q_status_t;

    typedef struct packed {
        logic pop;
    } sus_q_ctrl_t;

endpackage

@@ sv/sus_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sus_front: input side of the sorted unique set
// Accepts operation beats and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sus_front
    import sus_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [VALUE_W-1:0] value,
    output sus_op_t            q_op,
    output sus_q_status_t      q_status,
    input  sus_q_ctrl_t        q_ctrl
);

    sus_op_t     entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        push;
    logic        pop;

    assign in_stall       = (fill_reg == 2'd2);
    assign push           = in_valid && !in_stall;
    assign pop            = q_ctrl.pop && (fill_reg != 2'd0);
    assign q_status.valid = (fill_reg != 2'd0);
    assign q_op           = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{func: func, value: value};
        end
    end

endmodule

@@ sv/sus_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sus_back: set update and readout for the sorted unique set
// Applies one queued operation, then streams the set.
// ----------------------------------------------------------------------------
module sus_back
    import sus_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  sus_op_t            q_op,
    input  sus_q_status_t      q_status,
    output sus_q_ctrl_t        q_ctrl,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COUNT_W-1:0] set_count,
    output logic [POS_W-1:0]   position,
    output logic [VALUE_W-1:0] element,
    output logic               has_element,
    output logic               dropped_full,
    output logic               last
);

    localparam int EFF_CAP = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;
    localparam int IDX_W   = (EFF_CAP > 1) ? $clog2(EFF_CAP) : 1;
    localparam int CNT_W   = $clog2(EFF_CAP + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } sus_state_t;

    sus_state_t          state_reg;
    sus_state_t          state_next;
    logic [VALUE_W-1:0]  vals_reg [EFF_CAP];
    logic [VALUE_W-1:0]  ins_val  [EFF_CAP];
    logic [VALUE_W-1:0]  del_val  [EFF_CAP];
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic                drop_reg;
    logic                drop_next;
    logic [EFF_CAP-1:0]  lt_v;
    logic [EFF_CAP-1:0]  eq_v;
    logic                present;
    logic                full;
    logic                take;
    logic                do_ins;
    logic                do_del;
    logic                beat_done;

    // per-entry compare against the operand, masked to held entries
    always_comb
    begin
        for (int i = 0; i < EFF_CAP; i++)
        begin
            lt_v[i] = (CNT_W'(i) < count_reg) &&
                      ($signed(vals_reg[i]) < $signed(q_op.value));
            eq_v[i] = (CNT_W'(i) < count_reg) && (vals_reg[i] == q_op.value);
        end
    end

    assign present = |eq_v;
    assign full    = (count_reg == CNT_W'(EFF_CAP));
    assign take    = (state_reg == S_IDLE) && q_status.valid;
    assign do_ins  = take && (q_op.func == FUNC_INSERT) && !present && !full;
    assign do_del  = take && (q_op.func == FUNC_DELETE) && present;

    assign q_ctrl.pop = take;

    // shifted copies: open a slot at the lower bound, or close the matching slot
    always_comb
    begin
        ins_val[0] = lt_v[0] ? vals_reg[0] : q_op.value;
        for (int i = 1; i < EFF_CAP; i++)
        begin
            if (lt_v[i])
                ins_val[i] = vals_reg[i];
            else if (lt_v[i-1])
                ins_val[i] = q_op.value;
            else
                ins_val[i] = vals_reg[i-1];
        end
        for (int i = 0; i < EFF_CAP - 1; i++)
        begin
            del_val[i] = lt_v[i] ? vals_reg[i] : vals_reg[i+1];
        end
        del_val[EFF_CAP-1] = vals_reg[EFF_CAP-1];
    end

    // readout
    assign out_valid    = (state_reg == S_EMIT);
    assign has_element  = (count_reg != '0);
    assign set_count    = COUNT_W'(count_reg);
    assign position     = POS_W'(idx_reg);
    assign element      = has_element ? vals_reg[idx_reg] : '0;
    assign dropped_full = drop_reg;
    assign last         = !has_element || ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign beat_done    = out_valid && !out_stall;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        drop_next  = drop_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_EMIT;
                    idx_next   = '0;
                    drop_next  = (q_op.func == FUNC_INSERT) && !present && full;
                    if (do_ins)
                        count_next = count_reg + CNT_W'(1);
                    else if (do_del)
                        count_next = count_reg - CNT_W'(1);
                end
            end
            S_EMIT:
            begin
                if (beat_done)
                begin
                    if (last)
                        state_next = S_IDLE;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_ins)
        begin
            vals_reg <= ins_val;
        end
        else if (do_del)
        begin
            vals_reg <= del_val;
        end
    end

endmodule

@@ sv/sorted_unique_set_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_set_core: ordered set of distinct signed 32-bit values
// Insert/delete operations in, full ordered contents out after each one.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, func, value): one beat per operation,
//   func 0 inserts value, func 1 deletes it. Duplicate inserts and deletes of
//   absent values leave the set alone.
//   Output channel (out_valid/out_stall): after each operation the whole set
//   is streamed lowest value first, one beat per element, each with set_count
//   and position, and last on the final beat. An empty set yields a single
//   beat with has_element low. dropped_full is high on every beat of a run whose
//   insert was refused because the set already held min(CAPACITY, 16) values.
// Timing:
//   A two-entry front queue takes operations while the back end is busy.
//   The back end takes an operation from the queue in its idle state,
//   applies it on leaving that state (parallel compare and shift of the value
//   registers) and then streams the output beats in its emit state; it takes
//   the next operation only after the last beat of the run has been accepted.
//   While out_stall is high the current beat holds; the queue absorbs two
//   more operations before in_stall rises.
// Reset: empties the set and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_unique_set_core
    import sus_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COUNT_W-1:0] set_count,
    output logic [POS_W-1:0]   position,
    output logic [VALUE_W-1:0] element,
    output logic               has_element,
    output logic               dropped_full,
    output logic               last
);

    localparam int EFF_CAP = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

    sus_op_t       q_op;
    sus_q_status_t q_status;
    sus_q_ctrl_t   q_ctrl;

    // front: accept and buffer operations
    sus_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .value    (value),
        .q_op     (q_op),
        .q_status (q_status),
        .q_ctrl   (q_ctrl)
    );

    // back: apply the operation and stream the set
    sus_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_op         (q_op),
        .q_status     (q_status),
        .q_ctrl       (q_ctrl),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .set_count    (set_count),
        .position     (position),
        .element      (element),
        .has_element  (has_element),
        .dropped_full (dropped_full),
        .last         (last)
    );

    // element flag follows the count
    a_has_elem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (has_element == (set_count != '0)))
        else $error("has_element disagrees with set_count");

    // rank stays inside the held range
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && has_element) |-> (COUNT_W'(position) < set_count))
        else $error("position beyond set_count");

    // a refused insert only happens on a full set
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dropped_full) |-> (set_count == COUNT_W'(EFF_CAP)))
        else $error("dropped_full on a set that is not full");

    // a stalled input means the queue has work for the back end
    a_stall_q: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_status.valid)
        else $error("input stalled with empty queue");

endmodule
